// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== hw/rtl/ppc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

  localparam int LOCK_W   = 10;
  localparam int TRACK_W  = 7;
  localparam int SEG_W    = 7;
  localparam int ACT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 10;

  localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TRIGGER = 2'd1;
  localparam logic [ACT_W-1:0] ACT_END     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOCKOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BTN_LOCKOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_CEILING = 2'd2;

  localparam logic [LOCK_W-1:0]  TRIG_LOCKOUT_RST  = 10'd80;
  localparam logic [LOCK_W-1:0]  BTN_LOCKOUT_RST   = 10'd200;
  localparam logic [TRACK_W-1:0] TRACK_CEILING_RST = 7'd99;

  localparam logic [SEG_W-1:0] SEG_ERR = 7'h79;

  // control into one lockout counter
  typedef struct packed {
    logic dec;
    logic try_press;
  } lock_ctl_t;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic             units_digit_on;
    logic             decimal_point;
  } disp_t;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic               playing;
    logic               load_request;
    logic               play_request;
    logic               stop_request;
    disp_t              disp;
  } res_t;

  function automatic logic [SEG_W-1:0] digit_pattern(input logic [3:0] d);
    logic [SEG_W-1:0] p;
    unique case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = SEG_ERR;
    endcase
    return p;
  endfunction

  // divide by ten through reciprocal, exact for 7-bit values
  function automatic logic [3:0] tens_of(input logic [TRACK_W-1:0] t);
    logic [14:0] prod;
    prod = {8'd0, t} * 15'd205;
    return prod[14:11];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/player_panel_controller.sv =====
// channel | ports                                    | dir
// in      | in_valid, in_stall, in_action, in_*_pressed | beat into the block
// out     | out_valid, out_stall, out_track .. out_decimal_point | one beat per input beat
// cfg     | cfg_wr_en, cfg_index, cfg_wdata          | register write, no wait
// every input beat is worked in the cycle it is taken; its result beat is
// registered in the result register, or in the skid entry while that one is stalled
// a two-entry output (result register plus skid) keeps one beat per cycle
// flowing while out_stall stays low; in_stall rises only while both entries hold beats
// synchronous active-low reset clears counters, track, playing, scan digit
`timescale 1ns / 1ps
`default_nettype none

module player_panel_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ppc_pkg::ACT_W-1:0]     in_action,
  input  wire logic                          in_prev_pressed,
  input  wire logic                          in_next_pressed,
  input  wire logic                          in_stop_pressed,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ppc_pkg::TRACK_W-1:0]        out_track,
  output logic                               out_playing,
  output logic                               out_load_request,
  output logic                               out_play_request,
  output logic                               out_stop_request,
  output logic [ppc_pkg::SEG_W-1:0]          out_segments,
  output logic                               out_units_digit_on,
  output logic                               out_decimal_point,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ppc_pkg::CFG_W-1:0]     cfg_wdata
);
  import ppc_pkg::*;

  `include "assert_macros.svh"

  logic [LOCK_W-1:0]  trig_lockout_r, btn_lockout_r;
  logic [TRACK_W-1:0] track_ceiling_r;
  logic [TRACK_W-1:0] track_r, track_nxt, track_mid;
  logic               play_r, play_nxt;

  logic acc, tick, trig, end_act;
  logic trig_ok, prev_ok, next_ok, stop_ok;
  lock_ctl_t trig_ctl, prev_ctl, next_ctl, stop_ctl;
  disp_t disp;
  res_t  res;

  res_t out_r, out_nxt, skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic out_pop;

  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !in_stall;
  assign tick     = acc && (in_action == ACT_TICK);
  assign trig     = acc && (in_action == ACT_TRIGGER);
  assign end_act  = acc && (in_action == ACT_END);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_lockout_r  <= TRIG_LOCKOUT_RST;
      btn_lockout_r   <= BTN_LOCKOUT_RST;
      track_ceiling_r <= TRACK_CEILING_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TRIG_LOCKOUT:  trig_lockout_r  <= cfg_wdata;
        REG_BTN_LOCKOUT:   btn_lockout_r   <= cfg_wdata;
        REG_TRACK_CEILING: track_ceiling_r <= cfg_wdata[TRACK_W-1:0];
        default: ;
      endcase
    end
  end

  assign trig_ctl = '{dec: tick, try_press: trig};
  assign prev_ctl = '{dec: tick, try_press: tick && in_prev_pressed};
  assign next_ctl = '{dec: tick, try_press: tick && in_next_pressed};
  assign stop_ctl = '{dec: tick, try_press: tick && in_stop_pressed};

  ppc_lockout u_trig (.clk, .rst_n, .ctl(trig_ctl), .reload(trig_lockout_r), .accept(trig_ok));
  ppc_lockout u_prev (.clk, .rst_n, .ctl(prev_ctl), .reload(btn_lockout_r),  .accept(prev_ok));
  ppc_lockout u_next (.clk, .rst_n, .ctl(next_ctl), .reload(btn_lockout_r),  .accept(next_ok));
  ppc_lockout u_stop (.clk, .rst_n, .ctl(stop_ctl), .reload(btn_lockout_r),  .accept(stop_ok));

  // previous acts before next
  always_comb begin
    track_mid = track_r;
    if (prev_ok && track_r != '0) begin
      track_mid = track_r - TRACK_W'(1);
    end
    track_nxt = track_mid;
    if (next_ok && track_mid < track_ceiling_r) begin
      track_nxt = track_mid + TRACK_W'(1);
    end
  end

  always_comb begin
    play_nxt = play_r;
    if (trig_ok) begin
      play_nxt = 1'b1;
    end else if (end_act || stop_ok) begin
      play_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= '0;
      play_r  <= 1'b0;
    end else begin
      track_r <= track_nxt;
      play_r  <= play_nxt;
    end
  end

  ppc_display u_disp (
    .clk, .rst_n, .tick, .track(track_nxt), .playing(play_nxt), .disp
  );

  always_comb begin
    res.track        = track_nxt;
    res.playing      = play_nxt;
    res.load_request = prev_ok || next_ok;
    res.play_request = trig_ok;
    res.stop_request = play_r && (trig_ok || end_act || stop_ok);
    res.disp         = disp;
  end

  // result register with skid entry
  assign out_pop = out_valid_r && !out_stall;

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = acc;
      end else begin
        out_nxt       = res;
        out_valid_nxt = acc;
      end
    end else if (acc) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_track          = out_r.track;
  assign out_playing        = out_r.playing;
  assign out_load_request   = out_r.load_request;
  assign out_play_request   = out_r.play_request;
  assign out_stop_request   = out_r.stop_request;
  assign out_segments       = out_r.disp.segments;
  assign out_units_digit_on = out_r.disp.units_digit_on;
  assign out_decimal_point  = out_r.disp.decimal_point;

  `ASSERT_NEVER(a_skid_without_out, clk, rst_n, skid_valid_r && !out_valid_r, "skid holds a beat ahead of the result register")
  `ASSERT_CLK(a_end_stops, clk, rst_n, end_act |=> !play_r, "end of data left playback running")
  `ASSERT_CLK(a_stop_req_playing, clk, rst_n, (acc && res.stop_request) |-> play_r, "stop request while idle")
  `ASSERT_CLK(a_trig_plays, clk, rst_n, trig_ok |=> play_r, "accepted trigger did not start playback")

endmodule

`default_nettype wire

// ===== hw/rtl/ppc_lockout.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ppc_lockout (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ppc_pkg::lock_ctl_t   ctl,
  input  wire logic [ppc_pkg::LOCK_W-1:0] reload,
  output logic                      accept
);
  import ppc_pkg::*;

  logic [LOCK_W-1:0] count_r, count_nxt;
  logic              idle;

  assign idle   = (count_r == '0);
  assign accept = idle && ctl.try_press;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = reload;
    end else if (!idle && ctl.dec) begin
      count_nxt = count_r - LOCK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ppc_display.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ppc_display (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      tick,
  input  wire logic [ppc_pkg::TRACK_W-1:0] track,
  input  wire logic                      playing,
  output ppc_pkg::disp_t                 disp
);
  import ppc_pkg::*;

  logic       scan_r;
  logic [3:0] tens;
  logic [3:0] units;
  logic [6:0] tens_x10;

  assign tens     = tens_of(track);
  assign tens_x10 = 7'({tens, 3'b000} + {2'b00, tens, 1'b0});
  assign units    = 4'(track - tens_x10);

  always_comb begin
    disp = '0;
    if (tick) begin
      disp.units_digit_on = scan_r;
      if (scan_r) begin
        disp.segments      = digit_pattern(units);
        disp.decimal_point = playing;
      end else begin
        disp.segments = digit_pattern(tens);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= 1'b0;
    end else if (tick) begin
      scan_r <= ~scan_r;
    end
  end

endmodule

`default_nettype wire

// ===== test/player_panel_controller_tb.sv =====
`timescale 1ns / 1ps

module player_panel_controller_tb;
  import ppc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;
  localparam int BTN_PREV = 0;
  localparam int BTN_NEXT = 1;
  localparam int BTN_STOP = 2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             prev;
    logic             next;
    logic             stop;
  } beat_t;

  class panel_scoreboard;
    logic [LOCK_W-1:0]  trig_lockout;
    logic [LOCK_W-1:0]  btn_lockout;
    logic [TRACK_W-1:0] track_ceiling;
    logic [LOCK_W-1:0]  trig_count;
    logic [LOCK_W-1:0]  btn_count [3];
    logic [TRACK_W-1:0] track;
    logic               playing;
    logic               show_units;
    res_t               panel_due_q [$];
    int unsigned        fails;

    function new();
      trig_lockout  = TRIG_LOCKOUT_RST;
      btn_lockout   = BTN_LOCKOUT_RST;
      track_ceiling = TRACK_CEILING_RST;
      trig_count    = '0;
      foreach (btn_count[i]) btn_count[i] = '0;
      track         = '0;
      playing       = 1'b0;
      show_units    = 1'b0;
      fails         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_TRIG_LOCKOUT:  trig_lockout = val;
        REG_BTN_LOCKOUT:   btn_lockout = val;
        REG_TRACK_CEILING: track_ceiling = val[TRACK_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return panel_due_q.size();
    endfunction

    // lockout counter: idle counter accepts a press, busy counter counts down
    function bit take_press(int b, logic pressed);
      if (btn_count[b] == '0) begin
        if (pressed) begin
          btn_count[b] = btn_lockout;
          return 1'b1;
        end
        return 1'b0;
      end
      btn_count[b] = btn_count[b] - LOCK_W'(1);
      return 1'b0;
    endfunction

    function logic [SEG_W-1:0] seg_of(int unsigned d);
      case (d)
        0: return 7'h3F;
        1: return 7'h06;
        2: return 7'h5B;
        3: return 7'h4F;
        4: return 7'h66;
        5: return 7'h6D;
        6: return 7'h7D;
        7: return 7'h07;
        8: return 7'h7F;
        9: return 7'h6F;
        default: return SEG_ERR;
      endcase
    endfunction

    function void note_beat(beat_t b);
      res_t r;
      r = '0;
      case (b.action)
        ACT_TICK: begin
          if (trig_count != '0) trig_count = trig_count - LOCK_W'(1);
          if (take_press(BTN_PREV, b.prev)) begin
            if (track != '0) track = track - TRACK_W'(1);
            r.load_request = 1'b1;
          end
          if (take_press(BTN_NEXT, b.next)) begin
            if (track < track_ceiling) track = track + TRACK_W'(1);
            r.load_request = 1'b1;
          end
          if (take_press(BTN_STOP, b.stop)) begin
            r.stop_request = playing;
            playing = 1'b0;
          end
          r.disp.units_digit_on = show_units;
          if (show_units) begin
            r.disp.segments = seg_of(track % 10);
            r.disp.decimal_point = playing;
          end else begin
            r.disp.segments = seg_of(track / 10);
          end
          show_units = ~show_units;
        end
        ACT_TRIGGER: begin
          if (trig_count == '0) begin
            trig_count = trig_lockout;
            r.stop_request = playing;
            r.play_request = 1'b1;
            playing = 1'b1;
          end
        end
        ACT_END: begin
          r.stop_request = playing;
          playing = 1'b0;
        end
        default: ;
      endcase
      r.track = track;
      r.playing = playing;
      panel_due_q.push_back(r);
    endfunction

    function void check_field(string field, logic [9:0] want, logic [9:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        fails++;
      end
    endfunction

    function void check_panel_beat(res_t got);
      res_t want;
      if (panel_due_q.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
        return;
      end
      want = panel_due_q.pop_front();
      check_field("track", 10'(want.track), 10'(got.track));
      check_field("playing", 10'(want.playing), 10'(got.playing));
      check_field("load_request", 10'(want.load_request), 10'(got.load_request));
      check_field("play_request", 10'(want.play_request), 10'(got.play_request));
      check_field("stop_request", 10'(want.stop_request), 10'(got.stop_request));
      check_field("segments", 10'(want.disp.segments), 10'(got.disp.segments));
      check_field("units_digit_on", 10'(want.disp.units_digit_on),
                  10'(got.disp.units_digit_on));
      check_field("decimal_point", 10'(want.disp.decimal_point),
                  10'(got.disp.decimal_point));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [ACT_W-1:0]     in_action;
  logic                 in_prev_pressed;
  logic                 in_next_pressed;
  logic                 in_stop_pressed;
  logic                 out_valid;
  logic                 out_stall;
  logic [TRACK_W-1:0]   out_track;
  logic                 out_playing;
  logic                 out_load_request;
  logic                 out_play_request;
  logic                 out_stop_request;
  logic [SEG_W-1:0]     out_segments;
  logic                 out_units_digit_on;
  logic                 out_decimal_point;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  panel_scoreboard sb = new();
  int unsigned cycle_count = 0;
  bit in_burst = 1'b0;

  player_panel_controller i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_prev_pressed    (in_prev_pressed),
    .in_next_pressed    (in_next_pressed),
    .in_stop_pressed    (in_stop_pressed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_track          (out_track),
    .out_playing        (out_playing),
    .out_load_request   (out_load_request),
    .out_play_request   (out_play_request),
    .out_stop_request   (out_stop_request),
    .out_segments       (out_segments),
    .out_units_digit_on (out_units_digit_on),
    .out_decimal_point  (out_decimal_point),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == LIMIT_CYCLES);
    $display("player_panel_controller_tb: FAIL");
    $finish;
  end

  // both channels are sampled at the edge, before any driver update lands
  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_beat({in_action, in_prev_pressed, in_next_pressed, in_stop_pressed});
      if (out_valid && !out_stall) begin
        got = {out_track, out_playing, out_load_request, out_play_request,
               out_stop_request, out_segments, out_units_digit_on, out_decimal_point};
        sb.check_panel_beat(got);
      end
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // receiver back-pressure, with quiet stretches now and then
  initial begin
    int run;
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) run = $urandom_range(100, 300);
      else run = $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      hold = pick_gap(1'b0);
      if (hold == 0) hold = 1;
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
  end

  task automatic send_beat(input beat_t b);
    int gap;
    gap = pick_gap(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= b.action;
    in_prev_pressed <= b.prev;
    in_next_pressed <= b.next;
    in_stop_pressed <= b.stop;
    do @(posedge clk); while (in_stall);
  endtask

  // wait out every result, then the skid and result registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [LOCK_W-1:0] trig, input logic [LOCK_W-1:0] btn,
                                input logic [TRACK_W-1:0] tmax);
    write_reg(REG_TRIG_LOCKOUT, trig);
    write_reg(REG_BTN_LOCKOUT, btn);
    write_reg(REG_TRACK_CEILING, {3'b000, tmax});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic beat_t random_beat(int prev_pct, int next_pct, int stop_pct);
    beat_t b;
    int r;
    r = $urandom_range(0, 99);
    if (r < 68) b.action = ACT_TICK;
    else if (r < 83) b.action = ACT_TRIGGER;
    else if (r < 95) b.action = ACT_END;
    else b.action = ACT_IGNORED;
    b.prev = ($urandom_range(0, 99) < prev_pct);
    b.next = ($urandom_range(0, 99) < next_pct);
    b.stop = ($urandom_range(0, 99) < stop_pct);
    return b;
  endfunction

  task automatic run_phase(input int trig, input int btn, input int tmax, input int count,
                           input int prev_pct, input int next_pct, input int stop_pct);
    wait_idle();
    apply_settings(LOCK_W'(trig), LOCK_W'(btn), TRACK_W'(tmax));
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) in_burst = ($urandom_range(0, 3) == 0);
      send_beat(random_beat(prev_pct, next_pct, stop_pct));
    end
    in_burst = 1'b0;
  endtask

  initial begin
    beat_t opening [$];
    beat_t lockout_run [$];
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_action       <= ACT_TICK;
    in_prev_pressed <= 1'b0;
    in_next_pressed <= 1'b0;
    in_stop_pressed <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= REG_TRIG_LOCKOUT;
    cfg_wdata       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero lockouts: held buttons act on every tick, saturation at both ends
    opening = '{
      '{ACT_TICK, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK, 1'b1, 1'b0, 1'b0},
      '{ACT_TICK, 1'b1, 1'b1, 1'b1},
      '{ACT_TICK, 1'b0, 1'b1, 1'b0},
      '{ACT_TICK, 1'b0, 1'b1, 1'b0},
      '{ACT_TICK, 1'b0, 1'b1, 1'b0},
      '{ACT_TICK, 1'b0, 1'b1, 1'b0},
      '{ACT_TICK, 1'b0, 1'b1, 1'b0},
      '{ACT_TRIGGER, 1'b0, 1'b0, 1'b0},
      '{ACT_TRIGGER, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK, 1'b0, 1'b0, 1'b1},
      '{ACT_END, 1'b0, 1'b0, 1'b0},
      '{ACT_TRIGGER, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK, 1'b0, 1'b0, 1'b0},
      '{ACT_END, 1'b0, 1'b0, 1'b0},
      '{ACT_IGNORED, 1'b1, 1'b1, 1'b1},
      '{ACT_TICK, 1'b1, 1'b0, 1'b0}
    };
    apply_settings(10'd0, 10'd0, 7'd4);
    foreach (opening[i]) send_beat(opening[i]);

    // short lockouts: trigger and buttons ignored while their counters run
    lockout_run = '{
      '{ACT_TRIGGER, 1'b0, 1'b0, 1'b0},
      '{ACT_TRIGGER, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK, 1'b1, 1'b1, 1'b1},
      '{ACT_TICK, 1'b1, 1'b1, 1'b1},
      '{ACT_TICK, 1'b1, 1'b1, 1'b1},
      '{ACT_TRIGGER, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK, 1'b1, 1'b1, 1'b1}
    };
    wait_idle();
    apply_settings(10'd2, 10'd2, 7'd99);
    foreach (lockout_run[i]) send_beat(lockout_run[i]);

    // climb past 99 so the tens digit overflows, then lower the ceiling
    run_phase(0, 0, 127, 170, 5, 90, 10);
    run_phase(3, 2, 10, 150, 40, 40, 20);
    run_phase(TRIG_LOCKOUT_RST, BTN_LOCKOUT_RST, TRACK_CEILING_RST, 350, 50, 50, 30);
    repeat (4)
      run_phase($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 127), 110,
                $urandom_range(10, 90), $urandom_range(10, 90), $urandom_range(5, 50));
    run_phase(1023, 1023, 99, 120, 50, 50, 50);

    wait_idle();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("player_panel_controller_tb: PASS");
    end else begin
      $display("player_panel_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
